// ===== hdl/scsa_pkg.sv =====
// shared types, codes and defaults of the size class slot allocator
`timescale 1ns / 1ps

package scsa_pkg;

    // default configuration
    localparam int NUM_CLASSES_DEF    = 11;
    localparam int MIN_BLOCK_LOG2_DEF = 9;

    // fixed field widths
    localparam int SIZE_W   = 32;
    localparam int KIND_W   = 2;
    localparam int OFF_W    = 22;
    localparam int STATUS_W = 3;
    localparam int CLASS_W  = 4;
    localparam int TOP_W    = 5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GRANT    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FALLBACK = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FORWARD  = 3'd5;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // pointer kinds
    localparam logic [KIND_W-1:0] PK_NULL    = 2'd0;
    localparam logic [KIND_W-1:0] PK_OUTSIDE = 2'd1;
    localparam logic [KIND_W-1:0] PK_INSIDE  = 2'd2;

    // controller states
    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } scsa_cmd_t;

endpackage

// ===== hdl/scsa_ctrl.sv =====
// controller state machine of the size class slot allocator
`timescale 1ns / 1ps

module scsa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output scsa_pkg::scsa_cmd_t cmd_out
);

    scsa_pkg::state_t state_reg;
    scsa_pkg::state_t state_next;
    logic             done_reg;
    logic             done_next;

    // state and strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scsa_pkg::S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        cmd_out.load = 1'b0;
        cmd_out.exec = 1'b0;
        unique case (state_reg)
            scsa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_out.load = 1'b1;
                    state_next   = scsa_pkg::S_EXEC;
                end
            end
            scsa_pkg::S_EXEC:
            begin
                cmd_out.exec = 1'b1;
                done_next    = 1'b1;
                state_next   = scsa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = scsa_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != scsa_pkg::S_IDLE);
    assign done = done_reg;

endmodule

// ===== hdl/scsa_datapath.sv =====
// datapath of the size class slot allocator: input latch, decode, busy flags, result
`timescale 1ns / 1ps

module scsa_datapath #(
    parameter int NUM_CLASSES    = scsa_pkg::NUM_CLASSES_DEF,
    parameter int MIN_BLOCK_LOG2 = scsa_pkg::MIN_BLOCK_LOG2_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  scsa_pkg::scsa_cmd_t                 cmd_in,
    input  logic                                cmd,
    input  logic [scsa_pkg::SIZE_W-1:0]         req_size,
    input  logic [scsa_pkg::KIND_W-1:0]         ptr_kind,
    input  logic [scsa_pkg::OFF_W-1:0]          ptr_offset,
    output logic [scsa_pkg::STATUS_W-1:0]       status,
    output logic [scsa_pkg::OFF_W-1:0]          grant_offset,
    output logic [scsa_pkg::CLASS_W-1:0]        grant_class,
    output logic                                grant_slot
);

    // wide enough for the size, the top block and the slot 1 offset
    localparam int SPAN_W = MIN_BLOCK_LOG2 + NUM_CLASSES + 3;
    localparam int WIDE_W = ((SPAN_W > scsa_pkg::SIZE_W) ? SPAN_W : scsa_pkg::SIZE_W) + 1;
    localparam int CLS_W  = $clog2(NUM_CLASSES + 1);

    localparam logic [WIDE_W-1:0] BLK       = WIDE_W'(1) << MIN_BLOCK_LOG2;
    localparam logic [WIDE_W-1:0] TOP_BLK   = BLK << (NUM_CLASSES - 1);
    localparam logic [WIDE_W-1:0] MIN_SLOT  = BLK << 2;
    localparam logic [scsa_pkg::TOP_W-1:0] TOP_BIAS = scsa_pkg::TOP_W'(MIN_BLOCK_LOG2 + 2);
    localparam logic [scsa_pkg::TOP_W:0]   NCLS     = (scsa_pkg::TOP_W + 1)'(NUM_CLASSES);

    // latched item
    logic                          cmd_reg;
    logic [scsa_pkg::SIZE_W-1:0]   size_reg;
    logic [scsa_pkg::KIND_W-1:0]   kind_reg;
    logic [scsa_pkg::OFF_W-1:0]    off_reg;

    // busy flags, bit s = slot s taken
    logic [1:0] slot_busy_reg  [NUM_CLASSES];
    logic [1:0] slot_busy_next [NUM_CLASSES];

    // result registers
    logic [scsa_pkg::STATUS_W-1:0] status_reg;
    logic [scsa_pkg::STATUS_W-1:0] status_next;
    logic [scsa_pkg::OFF_W-1:0]    offset_reg;
    logic [scsa_pkg::OFF_W-1:0]    offset_next;
    logic [scsa_pkg::CLASS_W-1:0]  class_reg;
    logic [scsa_pkg::CLASS_W-1:0]  class_next;
    logic                          slot_reg;
    logic                          slot_next;

    // decode signals
    logic [WIDE_W-1:0]             size_wide;
    logic [WIDE_W-1:0]             off_wide;
    logic [CLS_W-1:0]              alloc_cls;
    logic [1:0]                    alloc_busy;
    logic [scsa_pkg::TOP_W-1:0]    top_bit;
    logic [scsa_pkg::TOP_W-1:0]    free_cls;
    logic                          free_slot;
    logic                          free_hit;
    logic                          alloc_hit;
    logic                          alloc_slot;

    // item latch
    always_ff @(posedge clk)
    begin
        if (cmd_in.load)
        begin
            cmd_reg  <= cmd;
            size_reg <= req_size;
            kind_reg <= ptr_kind;
            off_reg  <= ptr_offset;
        end
    end

    assign size_wide = WIDE_W'(size_reg);
    assign off_wide  = WIDE_W'(off_reg);

    // smallest class whose block holds the size
    always_comb
    begin
        alloc_cls = CLS_W'(NUM_CLASSES - 1);
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if ((BLK << c) >= size_wide)
            begin
                alloc_cls = CLS_W'(c);
            end
        end
    end

    // flags of the chosen class
    always_comb
    begin
        alloc_busy = 2'b00;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            if (alloc_cls == CLS_W'(i))
            begin
                alloc_busy = slot_busy_reg[i];
            end
        end
    end

    // highest set bit of the freed offset
    always_comb
    begin
        top_bit = '0;
        for (int i = 0; i < scsa_pkg::OFF_W; i++)
        begin
            if (off_reg[i])
            begin
                top_bit = scsa_pkg::TOP_W'(i);
            end
        end
    end

    assign free_cls  = top_bit - TOP_BIAS;
    assign free_slot = ((off_reg & (off_reg - scsa_pkg::OFF_W'(1))) != '0);

    // request decode and result
    always_comb
    begin
        status_next = scsa_pkg::ST_FORWARD;
        offset_next = '0;
        class_next  = '0;
        slot_next   = 1'b0;
        alloc_hit   = 1'b0;
        alloc_slot  = 1'b0;
        free_hit    = 1'b0;
        if (cmd_reg == scsa_pkg::CMD_ALLOC)
        begin
            priority if (size_wide > TOP_BLK)
            begin
                status_next = scsa_pkg::ST_FALLBACK;
            end
            else if (size_reg == '0)
            begin
                status_next = scsa_pkg::ST_ZERO;
            end
            else if (!alloc_busy[0])
            begin
                alloc_hit   = 1'b1;
                status_next = scsa_pkg::ST_GRANT;
                offset_next = scsa_pkg::OFF_W'(WIDE_W'(4) << (MIN_BLOCK_LOG2 + alloc_cls));
                class_next  = scsa_pkg::CLASS_W'(alloc_cls);
            end
            else if (!alloc_busy[1])
            begin
                alloc_hit   = 1'b1;
                alloc_slot  = 1'b1;
                status_next = scsa_pkg::ST_GRANT;
                offset_next = scsa_pkg::OFF_W'(WIDE_W'(6) << (MIN_BLOCK_LOG2 + alloc_cls));
                class_next  = scsa_pkg::CLASS_W'(alloc_cls);
                slot_next   = 1'b1;
            end
            else
            begin
                status_next = scsa_pkg::ST_FALLBACK;
            end
        end
        else
        begin
            priority if (kind_reg == scsa_pkg::PK_NULL)
            begin
                status_next = scsa_pkg::ST_IGNORED;
            end
            else if (kind_reg != scsa_pkg::PK_INSIDE)
            begin
                status_next = scsa_pkg::ST_FORWARD;
            end
            else if (off_reg == '0)
            begin
                status_next = scsa_pkg::ST_IGNORED;
            end
            else if (off_wide < MIN_SLOT)
            begin
                status_next = scsa_pkg::ST_FORWARD;
            end
            else if ({1'b0, free_cls} >= NCLS)
            begin
                status_next = scsa_pkg::ST_FORWARD;
            end
            else
            begin
                free_hit    = 1'b1;
                status_next = scsa_pkg::ST_FREED;
                class_next  = scsa_pkg::CLASS_W'(free_cls);
                slot_next   = free_slot;
            end
        end
    end

    // flag updates, one entry per class
    always_comb
    begin
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            slot_busy_next[i] = slot_busy_reg[i];
            if (alloc_hit && (alloc_cls == CLS_W'(i)))
            begin
                slot_busy_next[i][alloc_slot] = 1'b1;
            end
            if (free_hit && (free_cls == scsa_pkg::TOP_W'(i)))
            begin
                slot_busy_next[i][free_slot] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                slot_busy_reg[i] <= 2'b00;
            end
        end
        else if (cmd_in.exec)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                slot_busy_reg[i] <= slot_busy_next[i];
            end
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd_in.exec)
        begin
            status_reg <= status_next;
            offset_reg <= offset_next;
            class_reg  <= class_next;
            slot_reg   <= slot_next;
        end
    end

    assign status       = status_reg;
    assign grant_offset = offset_reg;
    assign grant_class  = class_reg;
    assign grant_slot   = slot_reg;

endmodule

// ===== hdl/size_class_slot_allocator_core.sv =====
// top level of the size class slot allocator
// the accepting edge latches the item; the execute state then registers the result and raises done with it
// a new item is taken only while the controller is idle, after the load and execute steps of the last one
// the busy flags are read and updated in the execute cycle; results cannot be stalled
// reset: asynchronous, active low; all slots are free at once, no clearing pass
`timescale 1ns / 1ps

module size_class_slot_allocator_core #(
    parameter int NUM_CLASSES    = scsa_pkg::NUM_CLASSES_DEF,
    parameter int MIN_BLOCK_LOG2 = scsa_pkg::MIN_BLOCK_LOG2_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [scsa_pkg::SIZE_W-1:0]   req_size,
    input  logic [scsa_pkg::KIND_W-1:0]   ptr_kind,
    input  logic [scsa_pkg::OFF_W-1:0]    ptr_offset,
    output logic                          done,
    output logic [scsa_pkg::STATUS_W-1:0] status,
    output logic [scsa_pkg::OFF_W-1:0]    grant_offset,
    output logic [scsa_pkg::CLASS_W-1:0]  grant_class,
    output logic                          grant_slot
);

    scsa_pkg::scsa_cmd_t ctrl_cmd;

    // controller
    scsa_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .done    (done),
        .cmd_out (ctrl_cmd)
    );

    // datapath
    scsa_datapath #(
        .NUM_CLASSES    (NUM_CLASSES),
        .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_in       (ctrl_cmd),
        .cmd          (cmd),
        .req_size     (req_size),
        .ptr_kind     (ptr_kind),
        .ptr_offset   (ptr_offset),
        .status       (status),
        .grant_offset (grant_offset),
        .grant_class  (grant_class),
        .grant_slot   (grant_slot)
    );

endmodule

// ===== hdl/scsa_checker.sv =====
// port level checker of the size class slot allocator and its bind
`timescale 1ns / 1ps

module scsa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [scsa_pkg::STATUS_W-1:0] status,
    input logic [scsa_pkg::OFF_W-1:0]    grant_offset
);

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // every accepted item gives its result, with busy low again, in the cycle after busy rises
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |=> (done && !busy))
        else $error("result strobe missing after accepted item");

    // the strobe only shows when a request was in flight
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without an item");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= scsa_pkg::ST_FORWARD))
        else $error("undefined status code");

    // only a grant carries an offset
    a_offset_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != scsa_pkg::ST_GRANT) |-> (grant_offset == '0))
        else $error("offset on a result that is not a grant");

endmodule

bind size_class_slot_allocator_core scsa_checker u_scsa_checker (.*);
